### hw/rtl/mhtc_pkg.sv
package mhtc_pkg;

  localparam logic [31:0] REUSE_RESET = 32'd86400;
  localparam int unsigned MULT_COUNT = 4;

  function automatic logic [31:0] mult_const(input logic [1:0] h);
    logic [31:0] m;
    unique case (h)
      2'd0: m = 32'd1072573589;
      2'd1: m = 32'd3465827623;
      2'd2: m = 32'd2848548977;
      default: m = 32'd748191707;
    endcase
    return m;
  endfunction

  typedef enum logic [2:0] {
    HS_IDLE,
    HS_MUL,
    HS_RCP,
    HS_QNB,
    HS_FIX
  } hs_state_t;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_READ,
    BK_WALK,
    BK_WRITE,
    BK_DONE
  } bk_state_t;

  typedef struct packed {
    logic        mode;
    logic [31:0] key;
    logic [31:0] now;
    logic [31:0] payload;
  } mhtc_cmd_t;

endpackage

### hw/rtl/mhtc_ram.sv
module mhtc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/mhtc_front.sv
module mhtc_front
  import mhtc_pkg::*;
#(
  parameter int NUM_BUCKETS = 1021,
  parameter int NUM_HASHES  = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            take,
  input  mhtc_cmd_t                       cmd,
  input  logic                            deq,
  output logic                            q_valid,
  output mhtc_cmd_t                       q_cmd,
  output logic [NUM_HASHES-1:0][$clog2(NUM_BUCKETS)-1:0] q_bkt
);

  localparam int BW = $clog2(NUM_BUCKETS);
  localparam logic [63:0] SPAN  = 64'h1_0000_0000;
  localparam logic [31:0] NB    = 32'(NUM_BUCKETS);
  localparam logic [31:0] RECIP = 32'(SPAN / 64'(NUM_BUCKETS));

  hs_state_t hs_r, hs_nxt;
  logic [1:0]  h_r, h_nxt;
  logic [31:0] prod_r;
  logic [31:0] quo_r;
  logic [31:0] rem_r;
  mhtc_cmd_t   cmd_r;
  logic [NUM_HASHES-1:0][BW-1:0] bkt_r;
  logic q_valid_r;
  logic [63:0] rcp_full;
  logic [31:0] qnb, red;
  logic        last_h;

  // reciprocal estimate of the quotient is low by at most one
  assign rcp_full = 64'(prod_r) * 64'(RECIP);
  assign qnb      = quo_r * NB;
  assign red      = (rem_r >= NB) ? rem_r - NB : rem_r;
  assign last_h   = (h_r == 2'(NUM_HASHES - 1));

  always_comb begin
    hs_nxt = hs_r;
    h_nxt  = h_r;
    unique case (hs_r)
      HS_IDLE: begin
        h_nxt = 2'd0;
        if (take) hs_nxt = HS_MUL;
      end
      HS_MUL: hs_nxt = HS_RCP;
      HS_RCP: hs_nxt = HS_QNB;
      HS_QNB: hs_nxt = HS_FIX;
      HS_FIX: begin
        if (last_h) begin
          hs_nxt = HS_IDLE;
        end else begin
          hs_nxt = HS_MUL;
          h_nxt  = h_r + 2'd1;
        end
      end
      default: hs_nxt = HS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hs_r      <= HS_IDLE;
      h_r       <= 2'd0;
      q_valid_r <= 1'b0;
    end else begin
      hs_r <= hs_nxt;
      h_r  <= h_nxt;
      if (hs_r == HS_FIX && last_h) begin
        q_valid_r <= 1'b1;
      end else if (deq) begin
        q_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hs_r == HS_IDLE && take) cmd_r <= cmd;
    if (hs_r == HS_MUL) prod_r <= cmd_r.key * mult_const(h_r);
    if (hs_r == HS_RCP) quo_r <= rcp_full[63:32];
    if (hs_r == HS_QNB) rem_r <= prod_r - qnb;
    if (hs_r == HS_FIX) bkt_r[h_r] <= red[BW-1:0];
  end

  assign q_valid = q_valid_r;
  assign q_cmd   = cmd_r;
  assign q_bkt   = bkt_r;

endmodule

### hw/rtl/mhtc_back.sv
module mhtc_back
  import mhtc_pkg::*;
#(
  parameter int NUM_BUCKETS = 1021,
  parameter int BUCKET_WAYS = 16,
  parameter int NUM_HASHES  = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [31:0]          reuse_delay,
  input  logic                 q_valid,
  input  mhtc_cmd_t            q_cmd,
  input  logic [NUM_HASHES-1:0][$clog2(NUM_BUCKETS)-1:0] q_bkt,
  output logic                 deq,
  output logic                 ready,
  output logic                 res_valid,
  output logic                 res_hit,
  output logic [31:0]          res_handle,
  output logic                 res_updated,
  output logic                 res_stored,
  output logic [13:0]          res_live
);

  localparam int DEPTH = NUM_BUCKETS * BUCKET_WAYS;
  localparam int AW    = $clog2(DEPTH);
  localparam int BW    = $clog2(NUM_BUCKETS);
  localparam int WW    = (BUCKET_WAYS > 1) ? $clog2(BUCKET_WAYS) : 1;
  localparam int LW    = $clog2(DEPTH + 1);
  localparam logic [LW-1:0] LIVE_MAX = LW'(DEPTH);

  bk_state_t st_r, st_nxt;
  logic [AW-1:0] clr_r;
  logic [1:0]    h_r;
  logic [WW-1:0] w_r;
  logic [LW-1:0] live_r;
  logic          done_r, have_r;
  logic [31:0]   min_r;
  logic [AW-1:0] vic_r, waddr_r;
  logic [31:0]   wkey_r, wstamp_r, whandle_r;
  logic          wr_r;
  logic          hit_r, upd_r, sto_r;
  logic [31:0]   hdl_r;
  logic          last_way, last_h;

  logic [AW-1:0] raddr, waddr;
  logic          we;
  logic [31:0]   wkey, wstamp, whandle;
  logic [31:0]   rkey, rstamp, rhandle;
  logic [AW-1:0] cur_idx;

  assign cur_idx = AW'(q_bkt[h_r]) * AW'(BUCKET_WAYS) + AW'(w_r);
  assign last_way = (w_r == WW'(BUCKET_WAYS - 1));
  assign last_h   = (h_r == 2'(NUM_HASHES - 1));

  mhtc_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_key (
    .clk, .we, .waddr, .wdata(wkey), .raddr, .rdata(rkey));
  mhtc_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_stamp (
    .clk, .we, .waddr, .wdata(wstamp), .raddr, .rdata(rstamp));
  mhtc_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_handle (
    .clk, .we, .waddr, .wdata(whandle), .raddr, .rdata(rhandle));

  assign raddr = cur_idx;
  always_comb begin
    if (st_r == BK_CLEAR) begin
      we = 1'b1; waddr = clr_r; wkey = '0; wstamp = '0; whandle = '0;
    end else begin
      we = wr_r; waddr = waddr_r; wkey = wkey_r; wstamp = wstamp_r; whandle = whandle_r;
    end
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      BK_CLEAR: if (clr_r == AW'(DEPTH - 1)) st_nxt = BK_IDLE;
      BK_IDLE:  if (q_valid) st_nxt = BK_READ;
      BK_READ:  st_nxt = BK_WALK;
      BK_WALK:  st_nxt = BK_READ;
      BK_WRITE: st_nxt = BK_DONE;
      BK_DONE:  st_nxt = BK_IDLE;
      default:  st_nxt = BK_IDLE;
    endcase
    if (st_r == BK_WALK) begin
      if (done_r || (last_way && last_h)) st_nxt = BK_WRITE;
    end
  end

  assign deq   = (st_r == BK_DONE);
  assign ready = (st_r == BK_IDLE) && !q_valid;

  logic match, stale;
  logic [31:0] lim;
  assign match = (rkey == q_cmd.key);
  assign lim   = rstamp + reuse_delay;
  assign stale = (lim < q_cmd.now);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= BK_CLEAR;
      clr_r     <= '0;
      live_r    <= '0;
      wr_r      <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      res_valid <= 1'b0;
      wr_r      <= 1'b0;
      if (st_r == BK_CLEAR) clr_r <= clr_r + AW'(1);
      if (st_r == BK_WALK && !done_r && match) begin
        if (!q_cmd.mode) begin
          if (stale) begin
            wr_r <= 1'b1;
            if (live_r != '0) live_r <= live_r - LW'(1);
          end
        end else begin
          wr_r <= 1'b1;
        end
      end
      if (st_r == BK_WALK && st_nxt == BK_WRITE && !done_r && !match && q_cmd.mode
          && (have_r || rstamp != 32'hFFFF_FFFF)) begin
        wr_r <= 1'b1;
        if ((rstamp < min_r ? rstamp : min_r) == 32'd0 && live_r < LIVE_MAX)
          live_r <= live_r + LW'(1);
      end
      if (st_r == BK_WRITE) res_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == BK_IDLE) begin
      h_r <= 2'd0; w_r <= '0; done_r <= 1'b0; have_r <= 1'b0;
      min_r <= 32'hFFFF_FFFF; hit_r <= 1'b0; hdl_r <= '0;
      upd_r <= 1'b0; sto_r <= 1'b0;
    end
    if (st_r == BK_WALK && !done_r) begin
      if (last_way) begin
        w_r <= '0; h_r <= h_r + 2'd1;
      end else begin
        w_r <= w_r + WW'(1);
      end
      if (match) begin
        done_r  <= 1'b1;
        waddr_r <= cur_idx;
        wkey_r  <= q_cmd.mode ? rkey : '0;
        wstamp_r <= q_cmd.mode ? q_cmd.now : '0;
        whandle_r <= q_cmd.mode ? q_cmd.payload : '0;
        if (q_cmd.mode) begin
          upd_r <= 1'b1; sto_r <= 1'b1;
        end else if (!stale) begin
          hit_r <= 1'b1; hdl_r <= rhandle;
        end
      end else if (q_cmd.mode) begin
        logic [AW-1:0] v;
        logic          hv;
        v  = vic_r;
        hv = have_r;
        if (rstamp < min_r) begin
          min_r <= rstamp; v = cur_idx; hv = 1'b1;
          vic_r <= cur_idx; have_r <= 1'b1;
        end
        if (last_way && last_h && hv) begin
          waddr_r <= v; wkey_r <= q_cmd.key; wstamp_r <= q_cmd.now;
          whandle_r <= q_cmd.payload; sto_r <= 1'b1;
        end
      end
    end
    if (st_r == BK_WRITE) begin
      res_hit <= hit_r; res_handle <= hdl_r; res_updated <= upd_r;
      res_stored <= sto_r; res_live <= 14'(live_r);
    end
  end

endmodule

### hw/rtl/multi_hash_timestamp_cache.sv
// Keyed cache mapping a 32-bit key to a 32-bit handle over NUM_HASHES buckets of
// BUCKET_WAYS ways. After reset a clearing pass over all NUM_BUCKETS*BUCKET_WAYS
// entries runs with busy high. A front part hashes the key one hash at a time
// (multiply, reciprocal quotient estimate, remainder, one correction), a back part
// walks the ways through the table memories, a read state and a walk state per way,
// stopping after the first key match or the last way, then writes back and strobes
// out_valid for one cycle; the receiver cannot stall. Busy drops the cycle after the
// strobe, so a new item is taken only once the previous one has completed.
module multi_hash_timestamp_cache
  import mhtc_pkg::*;
#(
  parameter int NUM_BUCKETS = 1021,
  parameter int BUCKET_WAYS = 16,
  parameter int NUM_HASHES  = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_mode,
  input  logic [31:0] in_key,
  input  logic [31:0] in_now,
  input  logic [31:0] in_payload,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  output logic        out_valid,
  output logic        out_hit,
  output logic [31:0] out_found_handle,
  output logic        out_updated,
  output logic        out_stored,
  output logic [13:0] out_live_entries
);

  localparam int BW = $clog2(NUM_BUCKETS);

  logic [31:0] reuse_r;
  logic        busy_r;
  logic        q_valid, deq, ready, take;
  mhtc_cmd_t   cmd, q_cmd;
  logic [NUM_HASHES-1:0][BW-1:0] q_bkt;

  assign busy = busy_r || !ready;
  assign take = start && !busy;
  assign cmd  = '{mode: in_mode, key: in_key, now: in_now, payload: in_payload};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reuse_r <= REUSE_RESET;
      busy_r  <= 1'b0;
    end else begin
      if (cfg_we) reuse_r <= cfg_wdata;
      if (take) busy_r <= 1'b1;
      else if (out_valid) busy_r <= 1'b0;
    end
  end

  mhtc_front #(.NUM_BUCKETS(NUM_BUCKETS), .NUM_HASHES(NUM_HASHES)) u_front (
    .clk, .rst_n, .take, .cmd, .deq, .q_valid, .q_cmd, .q_bkt);

  mhtc_back #(.NUM_BUCKETS(NUM_BUCKETS), .BUCKET_WAYS(BUCKET_WAYS),
              .NUM_HASHES(NUM_HASHES)) u_back (
    .clk, .rst_n, .reuse_delay(reuse_r), .q_valid, .q_cmd, .q_bkt, .deq, .ready,
    .res_valid(out_valid), .res_hit(out_hit), .res_handle(out_found_handle),
    .res_updated(out_updated), .res_stored(out_stored), .res_live(out_live_entries));

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> busy) else $error("busy not raised");
  a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy_r) else $error("busy stuck");
  a_hit_search: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_hit && out_stored)) else $error("hit and stored");

endmodule
